### rtl/tcld_pkg.sv
// Package for the text command line decoder: command codes, keyword table,
// phase codes and the control struct shared by the decoder's modules.
// Depends on nothing.
`default_nettype none

package tcld_pkg;

    // Keyword table dimensions.
    localparam int KW_COUNT   = 24;
    localparam int KW_MAX_LEN = 17;
    localparam int KW_TEXT_W  = 8 * KW_MAX_LEN;
    localparam int POS_W      = 5;
    localparam int ACC_W      = 16;
    localparam int VALUE_W    = 7;

    // Position saturation point and the length of the brightness prefix.
    localparam logic [POS_W-1:0]   POS_MAX     = 5'd18;
    localparam logic [POS_W-1:0]   PREFIX_LEN  = 5'd7;
    localparam logic [ACC_W-1:0]   PERCENT_MAX = 16'd100;

    // Character codes used by the number parser.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Command codes given at end of line.
    typedef enum logic [3:0] {
        CMD_PING        = 4'd0,
        CMD_STATUS      = 4'd1,
        CMD_AUTO        = 4'd2,
        CMD_MANUAL      = 4'd3,
        CMD_TOGGLE      = 4'd4,
        CMD_LED_ON      = 4'd5,
        CMD_LED_OFF     = 4'd6,
        CMD_UP          = 4'd7,
        CMD_DOWN        = 4'd8,
        CMD_SET         = 4'd9,
        CMD_COUNT_GET   = 4'd10,
        CMD_CNT_CLEAR   = 4'd11,
        CMD_UNKNOWN     = 4'd12
    } cmd_t;

    // Number parser phases.
    typedef enum logic [2:0] {
        PH_SKIP   = 3'b001,
        PH_DIGITS = 3'b010,
        PH_DONE   = 3'b100
    } phase_t;

    // Per-item control from the top level to the line state holders.
    typedef struct packed {
        logic take;
        logic clear;
    } step_ctl_t;

    // Keyword text, first character in the most significant used byte.
    localparam logic [KW_TEXT_W-1:0] KW_TEXT [KW_COUNT] = '{
        "PING", "GET", "STATUS?", "MODE=AUTO", {"MODE_", "AUTO"},
        "MODE=MANUAL", {"MODE_", "MANUAL"}, "MODE=TOGGLE", {"MODE_", "TOGGLE"},
        "LED=ON", "LED_ON", "LED=OFF", "LED_OFF",
        "BRIGHT+", {"BRIGHT_", "UP"}, "BRTI",
        "BRIGHT-", {"BRIGHT_", "DOWN"}, "BRTD",
        "BRIGHT=", "COUNT?", {"HUMAN_", "COUNT?"}, {"COUNT_", "RESET"},
        {"HUMAN_", "COUNT_", "RESET"}
    };

    localparam logic [POS_W-1:0] KW_LEN [KW_COUNT] = '{
        5'd4, 5'd3, 5'd7, 5'd9, 5'd9,
        5'd11, 5'd11, 5'd11, 5'd11,
        5'd6, 5'd6, 5'd7, 5'd7,
        5'd7, 5'd9, 5'd4,
        5'd7, 5'd11, 5'd4,
        5'd7, 5'd6, 5'd12, 5'd11,
        5'd17
    };

    localparam cmd_t KW_CODE [KW_COUNT] = '{
        CMD_PING, CMD_STATUS, CMD_STATUS, CMD_AUTO, CMD_AUTO,
        CMD_MANUAL, CMD_MANUAL, CMD_TOGGLE, CMD_TOGGLE,
        CMD_LED_ON, CMD_LED_ON, CMD_LED_OFF, CMD_LED_OFF,
        CMD_UP, CMD_UP, CMD_UP,
        CMD_DOWN, CMD_DOWN, CMD_DOWN,
        CMD_SET, CMD_COUNT_GET, CMD_COUNT_GET, CMD_CNT_CLEAR,
        CMD_CNT_CLEAR
    };

    // Only the brightness set keyword matches as a prefix.
    localparam logic [KW_COUNT-1:0] KW_IS_PREFIX = KW_COUNT'(1) << 19;

    // Character of keyword k at position pos; valid only while pos < length.
    function automatic logic [7:0] kw_char(input int k, input logic [POS_W-1:0] pos);
        int shift;
        shift = 8 * (int'(KW_LEN[k]) - 1 - int'(pos));
        if (shift < 0) begin
            shift = 0;
        end
        return 8'(KW_TEXT[k] >> shift);
    endfunction

endpackage

`default_nettype wire

### rtl/tcld_keyword_match.sv
// Keyword matcher: holds the per-keyword match bits and the character
// position, and decodes the command code at end of line. Uses tcld_pkg.
`default_nettype none

module tcld_keyword_match
    import tcld_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire step_ctl_t        ctl,
    input  wire logic [7:0]       char_byte,
    output cmd_t                  code,
    output logic                  past_prefix
);

    logic [KW_COUNT-1:0] alive_reg;
    logic [KW_COUNT-1:0] alive_next;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;

    // Drop every keyword whose character at this position differs, and every
    // exact keyword once the line runs past its end.
    always_comb begin
        alive_next = alive_reg;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (pos_reg < KW_LEN[k]) begin
                if (kw_char(k, pos_reg) != char_byte) begin
                    alive_next[k] = 1'b0;
                end
            end else if (!KW_IS_PREFIX[k]) begin
                alive_next[k] = 1'b0;
            end
        end
        pos_next = (pos_reg < POS_MAX) ? pos_reg + 5'd1 : pos_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            alive_reg <= '1;
            pos_reg   <= '0;
        end else if (ctl.take) begin
            alive_reg <= alive_next;
            pos_reg   <= pos_next;
        end
    end

    // The lowest-numbered live keyword whose length fits the line wins.
    always_comb begin
        code = CMD_UNKNOWN;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (alive_reg[k]) begin
                if (KW_IS_PREFIX[k] ? (pos_reg >= KW_LEN[k]) : (pos_reg == KW_LEN[k])) begin
                    code = KW_CODE[k];
                end
            end
        end
    end

    assign past_prefix = (pos_reg >= PREFIX_LEN);

endmodule

`default_nettype wire

### rtl/tcld_number_parse.sv
// Number parser for the text after the brightness prefix: whitespace, sign,
// decimal digits, wrapping at 16 bits, then the clamped percent. Uses tcld_pkg.
`default_nettype none

module tcld_number_parse
    import tcld_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire step_ctl_t          ctl,
    input  wire logic [7:0]         char_byte,
    output logic [VALUE_W-1:0]      percent
);

    phase_t             phase_reg;
    phase_t             phase_next;
    logic               negative_reg;
    logic               negative_next;
    logic [ACC_W-1:0]   accum_reg;
    logic [ACC_W-1:0]   accum_next;
    logic               is_space;
    logic               is_digit;
    logic               is_sign;
    logic [ACC_W-1:0]   raw;

    assign is_space = (char_byte == CHAR_SPACE) ||
                      (char_byte >= CHAR_TAB && char_byte <= CHAR_CR);
    assign is_digit = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);
    assign is_sign  = (char_byte == CHAR_PLUS) || (char_byte == CHAR_MINUS);

    // One character of the number: the accumulator takes times ten plus digit.
    always_comb begin
        phase_next    = phase_reg;
        negative_next = negative_reg;
        accum_next    = accum_reg;
        case (phase_reg)
            PH_SKIP: begin
                if (is_space) begin
                    phase_next = PH_SKIP;
                end else if (is_sign) begin
                    negative_next = (char_byte == CHAR_MINUS);
                    phase_next    = PH_DIGITS;
                end else if (is_digit) begin
                    accum_next = (accum_reg << 3) + (accum_reg << 1)
                               + {12'd0, char_byte[3:0]};
                    phase_next = PH_DIGITS;
                end else begin
                    phase_next = PH_DONE;
                end
            end
            PH_DIGITS: begin
                if (is_digit) begin
                    accum_next = (accum_reg << 3) + (accum_reg << 1)
                               + {12'd0, char_byte[3:0]};
                end else begin
                    phase_next = PH_DONE;
                end
            end
            PH_DONE: begin
                phase_next = PH_DONE;
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            phase_reg    <= PH_SKIP;
            negative_reg <= 1'b0;
            accum_reg    <= '0;
        end else if (ctl.take) begin
            phase_reg    <= phase_next;
            negative_reg <= negative_next;
            accum_reg    <= accum_next;
        end
    end

    // Apply the sign modulo 2^16, read as signed, and clamp to the percent range.
    always_comb begin
        raw = negative_reg ? (~accum_reg + 16'd1) : accum_reg;
        if (raw[ACC_W-1]) begin
            percent = '0;
        end else if (raw > PERCENT_MAX) begin
            percent = VALUE_W'(PERCENT_MAX);
        end else begin
            percent = raw[VALUE_W-1:0];
        end
    end

endmodule

`default_nettype wire

### rtl/text_command_line_decoder.sv
// Text command line decoder: one byte item per cycle while s_ready is high, one result per line.
// The result is valid in the cycle after the end-of-line item is accepted.
// Items are taken one every cycle while s_ready is high; the line state updates in a single pass.
// The result register frees s_ready while a result waits whenever m_ready is high.
// Reset (synchronous, aresetn low) clears the line state and the result valid.
// Depends on tcld_pkg, tcld_keyword_match and tcld_number_parse.
`default_nettype none

module text_command_line_decoder
    import tcld_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_char_byte,
    input  wire logic               s_line_end,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [3:0]              m_command_code,
    output logic [VALUE_W-1:0]      m_bright_value
);

    logic               accept;
    logic               ended_reg;
    logic               past_prefix;
    step_ctl_t          kw_ctl;
    step_ctl_t          num_ctl;
    cmd_t               code;
    logic [VALUE_W-1:0] percent;
    logic               m_valid_reg;
    cmd_t               m_code_reg;
    logic [VALUE_W-1:0] m_value_reg;

    // An item is taken whenever the result register is empty or being emptied.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // A character counts only before a zero byte; line end clears the line state.
    always_comb begin
        kw_ctl.take   = accept && !s_line_end && !ended_reg && (s_char_byte != CHAR_NUL);
        kw_ctl.clear  = accept && s_line_end;
        num_ctl.take  = kw_ctl.take && past_prefix;
        num_ctl.clear = kw_ctl.clear;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || kw_ctl.clear) begin
            ended_reg <= 1'b0;
        end else if (accept && !s_line_end && (s_char_byte == CHAR_NUL)) begin
            ended_reg <= 1'b1;
        end
    end

    tcld_keyword_match u_keyword_match (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (kw_ctl),
        .char_byte   (s_char_byte),
        .code        (code),
        .past_prefix (past_prefix)
    );

    tcld_number_parse u_number_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (num_ctl),
        .char_byte (s_char_byte),
        .percent   (percent)
    );

    // Result register, loaded at each accepted end-of-line item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (kw_ctl.clear) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (kw_ctl.clear) begin
            m_code_reg  <= code;
            m_value_reg <= (code == CMD_SET) ? percent : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_command_code = m_code_reg;
    assign m_bright_value = m_value_reg;

    // Checks on the decoder's own result path.
    a_value_only_for_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_code_reg != CMD_SET) |-> (m_value_reg == '0))
        else $error("bright value set on a command other than brightness set");

    a_value_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_value_reg <= VALUE_W'(PERCENT_MAX)))
        else $error("bright value above the percent range");

    a_result_after_line_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_line_end) |=> m_valid_reg)
        else $error("no result after an accepted end of line");

    a_no_result_from_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg && accept && !s_line_end) |=> !m_valid_reg)
        else $error("result raised by a character item");

    a_code_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_code_reg <= CMD_UNKNOWN))
        else $error("command code out of range");

endmodule

`default_nettype wire
